// ===== sv/tcce_pkg.sv =====
// Shared constants, codes and control types of the text console character engine.
package tcce_pkg;

	// Screen geometry and character cell layout
	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int TAB_STOP    = 8;
	localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

	localparam int COL_W       = 7;
	localparam int ROW_W       = 5;
	localparam int ADDR_W      = 11;
	localparam int CELL_W      = 16;
	localparam int OFF_W       = 12;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;

	// Blank cell after reset: space, grey on black
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
	localparam logic [7:0]        BLANK_CHAR = 8'h20;

	// Control character codes
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_HT = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT   = 3'd0,
		REG_TOP    = 3'd1,
		REG_COLS   = 3'd2,
		REG_ROWS   = 3'd3,
		REG_SCROLL = 3'd4,
		REG_FG     = 3'd5,
		REG_BG     = 3'd6,
		REG_CURSOR = 3'd7
	} cfg_reg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_DRAIN,
		ST_BLANK,
		ST_READ,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic clear_wr;
		logic exec;
		logic copy_step;
		logic blank_init;
		logic blank_step;
		logic resp_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last;
		logic scroll_go;
		logic rows_one;
		logic copy_last;
		logic blank_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== sv/text_console_character_engine_top.sv =====
// Top level of the text console character engine: stream ports, controller and datapath.
//
// Channel   Direction  Transfer condition      Contents
// s_*       in         s_tvalid & s_tready     tuser: func; tdata: char_code, read_addr
// m_*       out        m_tvalid & m_tready     tdata: cursor, hw offset, cell, scrolled
// cfg_*     in         cfg_we                  register index and write data
//
// An ordinary item passes through exec, store read and result load, then back to idle.
// A scroll adds a copy pass that moves each region row below the top up one row, a drain
// step when the region has more than one row, and a blanking pass over the bottom row,
// one cell per cycle over the single store write port.
// After reset a clearing pass blanks all 2000 store cells; no item is taken.
// A result waits in the output register; the block may take the next item then.
module text_console_character_engine_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// tdata: char_code [7:0], read_addr [18:8], zero [23:19]
	input  logic [tcce_pkg::IN_TDATA_W-1:0]     s_tdata,
	// tuser: func [0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// tdata: cursor_col [6:0], cursor_row [11:7], hw_cursor_offset [23:12],
	//        cell_value [39:24], scrolled [40], zero [47:41]
	output logic [tcce_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tcce_pkg::CFG_W-1:0]          cfg_wdata
);
	import tcce_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	// Sequence each item
	tcce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Unpack the input fields into the datapath
	tcce_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_func   (s_tuser),
		.in_char   (s_tdata[7:0]),
		.in_addr   (s_tdata[8 +: ADDR_W]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== sv/tcce_ctrl.sv =====
// Controller state machine of the text console character engine.
module tcce_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  tcce_pkg::dp_status_t   sts,
	output tcce_pkg::ctrl_cmd_t    cmd
);
	import tcce_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (!sts.scroll_go) state_d = ST_READ;
				else if (sts.rows_one) state_d = ST_BLANK;
				else state_d = ST_COPY;
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last copy write lands here; aim at the bottom row
				cmd.blank_init = 1'b1;
				state_d        = ST_BLANK;
			end
			ST_BLANK: begin
				cmd.blank_step = 1'b1;
				if (sts.blank_last) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.resp_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== sv/tcce_datapath.sv =====
// Datapath of the text console character engine: registers, cursor, screen store, result.
module tcce_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tcce_pkg::CFG_W-1:0]             cfg_wdata,
	input  logic                                   in_func,
	input  logic [7:0]                             in_char,
	input  logic [tcce_pkg::ADDR_W-1:0]            in_addr,
	input  tcce_pkg::ctrl_cmd_t                    cmd,
	output tcce_pkg::dp_status_t                   sts,
	input  logic                                   m_tready,
	output logic                                   m_tvalid,
	output logic [tcce_pkg::OUT_TDATA_W-1:0]       m_tdata
);
	import tcce_pkg::*;

	function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] r,
	                                                 input logic [COL_W-1:0] c);
		return ADDR_W'(ADDR_W'(r) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(c);
	endfunction

	function automatic logic [COL_W-1:0] clamp_left(input logic [COL_W-1:0] v);
		return (v < COL_W'(SCREEN_COLS)) ? v : COL_W'(SCREEN_COLS - 1);
	endfunction

	function automatic logic [ROW_W-1:0] clamp_top(input logic [ROW_W-1:0] v);
		return (v < ROW_W'(SCREEN_ROWS)) ? v : ROW_W'(SCREEN_ROWS - 1);
	endfunction

	localparam logic [OFF_W-1:0] HIDDEN_OFFSET = OFF_W'((SCREEN_ROWS + 1) * SCREEN_COLS);

	// Configuration registers
	logic [COL_W-1:0] left_q;
	logic [ROW_W-1:0] top_q;
	logic [COL_W-1:0] cols_q;
	logic [ROW_W-1:0] rows_q;
	logic             scroll_en_q;
	logic [3:0]       fg_q;
	logic [3:0]       bg_q;
	logic             shown_q;

	// Cursor and item registers
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic              func_q;
	logic [7:0]        char_q;
	logic [ADDR_W-1:0] addr_q;
	logic              scrolled_q;

	// Sequencing registers
	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [COL_W-1:0]  j_q;
	logic [ROW_W-1:0]  i_q;
	logic              cp_valid_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic              m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// Screen store
	logic [CELL_W-1:0] mem [0:CELL_COUNT-1];
	logic [CELL_W-1:0] rdata_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [CELL_W-1:0] wr_data;
	logic [ADDR_W-1:0] rd_addr;

	// Region clamped onto the screen
	logic [COL_W-1:0] left_e;
	logic [ROW_W-1:0] top_e;
	logic [COL_W-1:0] room_c;
	logic [ROW_W-1:0] room_r;
	logic [COL_W-1:0] cols_e;
	logic [ROW_W-1:0] rows_e;
	logic [7:0]       right_w;
	logic [5:0]       bottom_w;
	logic [7:0]       attr;

	assign left_e   = clamp_left(left_q);
	assign top_e    = clamp_top(top_q);
	assign room_c   = COL_W'(SCREEN_COLS) - left_e;
	assign room_r   = ROW_W'(SCREEN_ROWS) - top_e;
	assign cols_e   = (cols_q == '0) ? COL_W'(1) : ((cols_q < room_c) ? cols_q : room_c);
	assign rows_e   = (rows_q == '0) ? ROW_W'(1) : ((rows_q < room_r) ? rows_q : room_r);
	assign right_w  = {1'b0, left_e} + {1'b0, cols_e};
	assign bottom_w = {1'b0, top_e} + {1'b0, rows_e};
	assign attr     = {bg_q, fg_q};

	// Interpret the character against the cursor
	logic [7:0] col_n;
	logic [5:0] row_n;
	logic       printable;
	logic       need_scroll;

	always_comb begin
		col_n       = {1'b0, cur_col_q};
		row_n       = {1'b0, cur_row_q};
		need_scroll = 1'b0;
		printable   = !char_q[7] && (char_q[6:5] != 2'b00);
		case (char_q)
			CH_BS: begin
				if (cur_col_q > left_e) begin
					col_n = col_n - 8'd1;
				end else if (cur_row_q > top_e) begin
					col_n = right_w - 8'd1;
					row_n = row_n - 6'd1;
				end
			end
			CH_CR: begin
				col_n = {1'b0, left_e};
			end
			CH_LF: begin
				col_n = {1'b0, left_e};
				row_n = row_n + 6'd1;
			end
			CH_HT: begin
				col_n = col_n + 8'(TAB_STOP) - 8'(cur_col_q % TAB_STOP);
			end
			default: begin
				if (printable) col_n = col_n + 8'd1;
			end
		endcase
		// wrap at the right edge
		if (col_n >= right_w) begin
			col_n = {1'b0, left_e};
			row_n = row_n + 6'd1;
		end
		// hold on the bottom row, scrolling if enabled
		if (row_n >= bottom_w) begin
			need_scroll = scroll_en_q;
			row_n       = bottom_w - 6'd1;
		end
	end

	logic put_en;
	logic addr_ok;

	assign put_en  = cmd.exec && !func_q && printable;
	assign addr_ok = addr_q < ADDR_W'(CELL_COUNT);

	// Status to the controller
	assign sts.clear_last = (clr_q == ADDR_W'(CELL_COUNT - 1));
	assign sts.scroll_go  = !func_q && need_scroll;
	assign sts.rows_one   = (rows_e == ROW_W'(1));
	assign sts.copy_last  = (i_q == ROW_W'(rows_e - ROW_W'(2))) &&
	                        (j_q == COL_W'(cols_e - COL_W'(1)));
	assign sts.blank_last = (j_q == COL_W'(cols_e - COL_W'(1)));
	assign sts.out_free   = !m_valid_q || m_tready;

	// Select the store write: clear pass, copy, put, blank
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = ptr_q;
		wr_data = {attr, BLANK_CHAR};
		if (cmd.clear_wr) begin
			wr_addr = clr_q;
			wr_data = BLANK_CELL;
		end else if (cp_valid_s1) begin
			wr_addr = dst_s1;
			wr_data = rdata_q;
		end else if (put_en) begin
			wr_addr = cell_index(cur_row_q, cur_col_q);
			wr_data = {attr, char_q};
		end else if (!cmd.blank_step) begin
			wr_en = 1'b0;
		end
	end

	assign rd_addr = cmd.copy_step ? ptr_q : (addr_ok ? addr_q : '0);

	// Screen store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	// Configuration registers and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			top_q       <= '0;
			cols_q      <= COL_W'(SCREEN_COLS);
			rows_q      <= ROW_W'(SCREEN_ROWS);
			scroll_en_q <= 1'b1;
			fg_q        <= 4'd7;
			bg_q        <= 4'd0;
			shown_q     <= 1'b1;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LEFT: begin
					left_q    <= cfg_wdata;
					cur_col_q <= clamp_left(cfg_wdata);
					cur_row_q <= top_e;
				end
				REG_TOP: begin
					top_q     <= cfg_wdata[ROW_W-1:0];
					cur_col_q <= left_e;
					cur_row_q <= clamp_top(cfg_wdata[ROW_W-1:0]);
				end
				REG_COLS: begin
					cols_q    <= cfg_wdata;
					cur_col_q <= left_e;
					cur_row_q <= top_e;
				end
				REG_ROWS: begin
					rows_q    <= cfg_wdata[ROW_W-1:0];
					cur_col_q <= left_e;
					cur_row_q <= top_e;
				end
				REG_SCROLL: scroll_en_q <= cfg_wdata[0];
				REG_FG:     fg_q        <= cfg_wdata[3:0];
				REG_BG:     bg_q        <= cfg_wdata[3:0];
				REG_CURSOR: shown_q     <= cfg_wdata[0];
				default: ;
			endcase
		end else if (cmd.exec && !func_q) begin
			cur_col_q <= col_n[COL_W-1:0];
			cur_row_q <= row_n[ROW_W-1:0];
		end
	end

	// Control flags: clear sweep, copy pipeline, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cp_valid_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cmd.clear_wr) clr_q <= clr_q + ADDR_W'(1);
			cp_valid_s1 <= cmd.copy_step;
			if (cmd.resp_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// Item latch, scroll walk pointers and result register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= in_func;
			char_q <= in_char;
			addr_q <= in_addr;
		end
		if (cmd.exec) begin
			scrolled_q <= !func_q && need_scroll;
			ptr_q      <= cell_index(sts.rows_one ? top_e : top_e + ROW_W'(1), left_e);
			i_q        <= '0;
			j_q        <= '0;
		end
		if (cmd.copy_step) begin
			dst_s1 <= ptr_q - ADDR_W'(SCREEN_COLS);
			if (j_q == COL_W'(cols_e - COL_W'(1))) begin
				j_q   <= '0;
				i_q   <= i_q + ROW_W'(1);
				ptr_q <= ptr_q + ADDR_W'(SCREEN_COLS + 1) - ADDR_W'(cols_e);
			end else begin
				j_q   <= j_q + COL_W'(1);
				ptr_q <= ptr_q + ADDR_W'(1);
			end
		end
		if (cmd.blank_init) begin
			ptr_q <= cell_index(ROW_W'(bottom_w - 6'd1), left_e);
			j_q   <= '0;
		end
		if (cmd.blank_step) begin
			ptr_q <= ptr_q + ADDR_W'(1);
			j_q   <= j_q + COL_W'(1);
		end
		if (cmd.resp_load) begin
			m_data_q <= {7'd0,
			             scrolled_q,
			             addr_ok ? rdata_q : CELL_W'(0),
			             shown_q ? OFF_W'(OFF_W'(cur_row_q) * OFF_W'(SCREEN_COLS))
			                       + OFF_W'(cur_col_q)
			                     : HIDDEN_OFFSET,
			             cur_row_q,
			             cur_col_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
	a_col_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q >= left_e) && ({1'b0, cur_col_q} < right_w))
		else $error("cursor column left the draw region");
	a_row_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_row_q >= top_e) && ({1'b0, cur_row_q} < bottom_w))
		else $error("cursor row left the draw region");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp_load |-> (!m_valid_q || m_tready))
		else $error("result loaded over a pending transfer");
	a_copy_dst: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid_s1 |-> (dst_s1 < ADDR_W'(CELL_COUNT)) && !cmd.clear_wr && !put_en)
		else $error("scroll copy write out of range or colliding");
`endif

endmodule
